@@ sv/page_bitmap_range_allocator_assert.svh @@
// Assertion macros for the page bitmap range allocator.
`ifndef PAGE_BITMAP_RANGE_ALLOCATOR_ASSERT_SVH
`define PAGE_BITMAP_RANGE_ALLOCATOR_ASSERT_SVH
`ifndef SYNTH
`define PBRA_ASSERT_IMPL(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define PBRA_ASSERT_NORST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define PBRA_ASSERT_IMPL(label, clk, rst, prop, msg)
`define PBRA_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

@@ sv/pbra_pkg.sv @@
// Shared types and codes for the page bitmap range allocator.
`default_nettype none
package pbra_pkg;
  localparam int PAGE_TOTAL = 65536;

  localparam logic [2:0] REQ_FREE    = 3'd0;
  localparam logic [2:0] REQ_RESERVE = 3'd1;
  localparam logic [2:0] REQ_LOW     = 3'd2;
  localparam logic [2:0] REQ_HIGH    = 3'd3;
  localparam logic [2:0] REQ_TEST    = 3'd4;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_SCAN_WAIT,
    ST_DECIDE,
    ST_WRITE,
    ST_WRITE_WAIT,
    ST_TEST_WAIT,
    ST_DONE
  } state_t;
endpackage
`default_nettype wire

@@ sv/pbra_bitmap.sv @@
// Bitmap store of one bit per page, one word per address, with a write port and a registered read port.
`default_nettype none
module pbra_bitmap #(
  parameter int WORDS = 1024,
  parameter int WBITS = 64,
  parameter int AW = 10
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WBITS-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WBITS-1:0] rdata
);
  logic [WBITS-1:0] mem [WORDS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ sv/pbra_engine.sv @@
// Sequencer that walks bitmap words one at a time for every request that touches the bitmap.
`default_nettype none
module pbra_engine #(
  parameter int WORD_BITS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [16:0] page_limit,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  req_type,
  input  wire logic [15:0] start_page,
  input  wire logic [16:0] page_count,
  input  wire logic [4:0]  align_log2,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             ok,
  output logic [15:0]      found_page,
  output logic             page_allocated,
  output logic             busy
);
  import pbra_pkg::*;

  localparam int WORDS = (PAGE_TOTAL + WORD_BITS - 1) / WORD_BITS;
  localparam int AW = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int BW = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
  localparam int PW = $clog2(PAGE_TOTAL) + 2;

  state_t state, state_next;

  logic [PW-1:0] lim, lfp, pg, n, cur, hi, lo, top;
  logic [2:0]    op;
  logic [4:0]    al;
  logic          topv, okr, tested, wval, wr_last;
  logic [AW-1:0] waddr, raddr;
  logic [WORD_BITS-1:0] wdata, rdata;
  logic          we;

  logic [PW-1:0] mask, alignv, cand;
  logic [PW-1:0] wbase, wend;
  logic [WORD_BITS-1:0] rmask, hits;
  logic [BW-1:0] hbit;
  logic          hany;

  assign alignv = (al > 5'(PW-1)) ? (PW'(1) << (PW-1)) : (PW'(1) << al);
  assign mask = ~(alignv - PW'(1));
  assign lim = (17'(page_limit) > 17'(PAGE_TOTAL)) ? PW'(PAGE_TOTAL) : PW'(page_limit);
  assign cand = (op == REQ_LOW) ? (lfp & mask) : ((lim - n) & mask);

  pbra_bitmap #(.WORDS(WORDS), .WBITS(WORD_BITS), .AW(AW)) u_map (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign wbase = {cur[PW-1:BW], {BW{1'b0}}};
  assign wend = wbase + PW'(WORD_BITS);

  always_comb begin
    rmask = '0;
    for (int b = 0; b < WORD_BITS; b++) begin
      rmask[b] = ((wbase + PW'(b)) >= lo) && ((wbase + PW'(b)) < hi);
    end
    hits = rdata & rmask;
    hany = |hits;
    hbit = '0;
    for (int b = 0; b < WORD_BITS; b++) begin
      if (hits[b]) hbit = BW'(b);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      cur <= '0;
      lfp <= PW'(PAGE_TOTAL);
    end else begin
      state <= state_next;
      case (state)
        ST_CLEAR: cur <= cur + PW'(WORD_BITS);
        ST_IDLE: if (in_valid) begin
          op <= req_type; al <= align_log2;
          n <= PW'(page_count); pg <= PW'(start_page);
          okr <= 1'b0; tested <= 1'b0; topv <= 1'b0;
        end
        ST_CHECK: begin
          topv <= 1'b0;
          wval <= (op != REQ_FREE);
          case (op)
            REQ_LOW, REQ_HIGH: begin
              pg <= cand; lo <= cand; hi <= cand + n; cur <= cand + n - PW'(1);
            end
            REQ_FREE: begin
              lo <= pg; hi <= pg + n; cur <= pg;
              if (pg + n <= lim) begin
                okr <= 1'b1;
                if (n != 0 && pg < lfp) lfp <= pg;
              end
            end
            REQ_RESERVE: begin
              lo <= pg; hi <= pg + n; cur <= pg + n - PW'(1);
              if (pg + n <= lim && n == 0) okr <= 1'b1;
            end
            REQ_TEST: begin
              cur <= pg;
              if (pg < lim) okr <= 1'b1;
            end
            default: ;
          endcase
        end
        ST_SCAN_WAIT: begin
          if (hany) begin
            topv <= 1'b1; top <= wbase + PW'(hbit);
          end else if (wbase > lo) begin
            cur <= wbase - PW'(1);
          end
        end
        ST_DECIDE: begin
          topv <= 1'b0;
          if (!topv) begin
            if (op != REQ_RESERVE) found_page <= pg[15:0];
            okr <= 1'b1;
            cur <= pg;
          end else if (op == REQ_LOW) begin
            pg <= (top + alignv) & mask;
            lo <= (top + alignv) & mask;
            hi <= ((top + alignv) & mask) + n;
            cur <= ((top + alignv) & mask) + n - PW'(1);
          end else begin
            pg <= (top - n) & mask;
            lo <= (top - n) & mask;
            hi <= ((top - n) & mask) + n;
            cur <= ((top - n) & mask) + n - PW'(1);
          end
        end
        ST_WRITE_WAIT: cur <= wend;
        ST_TEST_WAIT: tested <= okr & rdata[cur[BW-1:0]];
        ST_DONE: if (out_ready) begin
          found_page <= '0;
        end
        default: ;
      endcase
      if (state == ST_IDLE) found_page <= '0;
    end
  end

  always_comb begin
    state_next = state;
    we = 1'b0;
    waddr = cur[AW+BW-1:BW];
    raddr = cur[AW+BW-1:BW];
    wdata = rdata;
    in_ready = 1'b0;
    out_valid = 1'b0;
    wr_last = (wend >= hi);
    for (int b = 0; b < WORD_BITS; b++) begin
      if (rmask[b]) wdata[b] = wval;
    end
    case (state)
      ST_CLEAR: begin
        we = 1'b1; wdata = '1;
        if (cur + PW'(WORD_BITS) >= PW'(WORDS * WORD_BITS)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        raddr = pg[AW+BW-1:BW];
        state_next = ST_DONE;
        case (op)
          REQ_FREE: if (pg + n <= lim && n != 0) state_next = ST_WRITE;
          REQ_RESERVE: if (pg + n <= lim && n != 0) state_next = ST_SCAN;
          REQ_LOW: if (n != 0 && (lfp & mask) + n <= lim) state_next = ST_SCAN;
          REQ_HIGH: if (n != 0 && n <= lim && ((lim - n) & mask) >= lfp)
            state_next = ST_SCAN;
          REQ_TEST: if (pg < lim) state_next = ST_TEST_WAIT;
          default: ;
        endcase
      end
      ST_SCAN: state_next = ST_SCAN_WAIT;
      ST_SCAN_WAIT: begin
        if (hany) state_next = ST_DECIDE;
        else if (wbase > lo) state_next = ST_SCAN;
        else state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (!topv) state_next = ST_WRITE;
        else if (op == REQ_RESERVE) state_next = ST_DONE;
        else if (op == REQ_LOW) begin
          if (((top + alignv) & mask) + n <= lim) state_next = ST_SCAN;
          else state_next = ST_DONE;
        end else begin
          if (top < n || ((top - n) & mask) < lfp) state_next = ST_DONE;
          else state_next = ST_SCAN;
        end
      end
      ST_WRITE: state_next = ST_WRITE_WAIT;
      ST_WRITE_WAIT: begin
        we = 1'b1;
        state_next = wr_last ? ST_DONE : ST_WRITE;
      end
      ST_TEST_WAIT: state_next = ST_DONE;
      ST_DONE: begin
        out_valid = 1'b1;
        if (out_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign ok = okr;
  assign page_allocated = tested;
  assign busy = (state != ST_IDLE);
endmodule
`default_nettype wire

@@ sv/page_bitmap_range_allocator.sv @@
// Top level of the page bitmap range allocator.
// Keeps one allocated bit per page and serves one request at a time: free and reserve
// ranges, lowest or highest aligned run allocation, and page tests. After reset a
// clearing pass writes every bitmap word and marks every page allocated before the
// first word is accepted. The bitmap is walked one word at a time through the single
// read port. A free writes the words of its range; a reserve or allocation first scans
// its run from the top word down for an allocated page and then writes the run, and a
// search moves on to a new candidate for every one it rejects. A page test reads one
// word, and a request that touches no bitmap word goes straight to its result.
// The result word is held until taken.
`default_nettype none
module page_bitmap_range_allocator #(
  parameter int WORD_BITS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [16:0] cfg_data,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,   // start_page, page_count, align_log2, zero fill
  input  wire logic [2:0]  s_axis_tuser,   // req_type
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // ok, found_page, page_allocated, zero fill
  output logic             m_axis_tuser    // unused, zero
);
  import pbra_pkg::*;

  logic [16:0] page_limit;
  logic ok, pa, busy;
  logic [15:0] fp;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) page_limit <= 17'd65536;
    else if (cfg_valid) page_limit <= cfg_data;
  end

  pbra_engine #(.WORD_BITS(WORD_BITS)) u_engine (
    .clk(clk), .rst(rst), .page_limit(page_limit),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .req_type(s_axis_tuser), .start_page(s_axis_tdata[15:0]),
    .page_count(s_axis_tdata[32:16]), .align_log2(s_axis_tdata[37:33]),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .ok(ok), .found_page(fp), .page_allocated(pa), .busy(busy)
  );

  assign m_axis_tdata = {6'd0, pa, fp, ok};
  assign m_axis_tuser = 1'b0;

`include "page_bitmap_range_allocator_assert.svh"
  `PBRA_ASSERT_IMPL(a_no_accept_busy, clk, rst, s_axis_tready |-> !m_axis_tvalid, "ready while result pending")
  `PBRA_ASSERT_IMPL(a_fail_no_page, clk, rst, (m_axis_tvalid && !ok) |-> (fp == 16'd0 && !pa), "failed result carries data")
  `PBRA_ASSERT_NORST(a_busy_ready, clk, busy |-> !s_axis_tready, "accepting while busy")
endmodule
`default_nettype wire

@@ dv/tb.sv @@
// Self-checking testbench for the page bitmap range allocator.
`default_nettype none
module tb;
  import pbra_pkg::*;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] start;
    logic [16:0] count;
    logic [4:0]  align;
  } page_req_t;

  typedef struct packed {
    logic        ok;
    logic [15:0] found;
    logic        tested;
  } page_rsp_t;

  localparam int NUM_PAGES = 65536;
  localparam int STALL_LIMIT = 200000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [16:0] cfg_data = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic [2:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tuser;

  page_bitmap_range_allocator dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  always #2 clk = ~clk;

  bit [NUM_PAGES-1:0] page_busy;
  longint unsigned lowest_freed;
  longint unsigned page_lim;

  page_req_t pending_reqs[$];
  page_rsp_t expected_rsps[$];
  page_req_t cur_req;
  int tx_idle_pct = 9;
  int rx_idle_pct = 46;
  int errors = 0;
  int rsp_seen = 0;
  int hold_cycles = 0;
  int quiet_cycles = 0;

  function automatic longint top_busy(longint unsigned pg, longint unsigned n);
    longint unsigned p;
    for (longint unsigned j = n; j > 0; j--) begin
      p = pg + j - 1;
      if (p >= NUM_PAGES || page_busy[p]) return longint'(j - 1);
    end
    return -1;
  endfunction

  function automatic void mark_run(longint unsigned pg, longint unsigned n, bit v);
    for (longint unsigned i = 0; i < n; i++)
      if (pg + i < NUM_PAGES) page_busy[pg + i] = v;
  endfunction

  function automatic page_rsp_t serve_page_req(page_req_t r);
    page_rsp_t rsp;
    longint unsigned n, algn, mask, lim, pg;
    longint j;
    rsp = '0;
    n = 64'(r.count);
    algn = 64'd1 << r.align;
    mask = ~(algn - 1);
    lim = (page_lim > NUM_PAGES) ? 64'(NUM_PAGES) : page_lim;
    case (r.kind)
      REQ_FREE: begin
        if (r.start + n <= lim) begin
          rsp.ok = 1'b1;
          if (n > 0) begin
            mark_run(64'(r.start), n, 1'b0);
            if (r.start < lowest_freed) lowest_freed = 64'(r.start);
          end
        end
      end
      REQ_RESERVE: begin
        if (r.start + n <= lim && top_busy(64'(r.start), n) < 0) begin
          mark_run(64'(r.start), n, 1'b1);
          rsp.ok = 1'b1;
        end
      end
      REQ_LOW: begin
        if (n != 0) begin
          pg = lowest_freed & mask;
          while (pg + n <= lim) begin
            j = top_busy(pg, n);
            if (j < 0) begin
              mark_run(pg, n, 1'b1);
              rsp.ok = 1'b1;
              rsp.found = pg[15:0];
              break;
            end
            pg = (pg + longint'(j) + algn) & mask;
          end
        end
      end
      REQ_HIGH: begin
        if (n != 0 && n <= lim) begin
          pg = (lim - n) & mask;
          while (pg >= lowest_freed) begin
            j = top_busy(pg, n);
            if (j < 0) begin
              mark_run(pg, n, 1'b1);
              rsp.ok = 1'b1;
              rsp.found = pg[15:0];
              break;
            end
            if (pg + longint'(j) < n) break;
            pg = (pg + longint'(j) - n) & mask;
          end
        end
      end
      REQ_TEST: begin
        if (r.start < lim) begin
          rsp.ok = 1'b1;
          rsp.tested = page_busy[r.start];
        end
      end
      default: ;
    endcase
    return rsp;
  endfunction

  function automatic page_req_t make_req(logic [2:0] kind, int start, int count, int align);
    page_req_t r;
    r.kind = kind;
    r.start = start[15:0];
    r.count = count[16:0];
    r.align = align[4:0];
    return r;
  endfunction

  function automatic page_req_t random_req(int lim, bit allow_search);
    page_req_t r;
    int roll, cnt_top;
    roll = $urandom_range(0, 99);
    if (roll < 28) r.kind = REQ_FREE;
    else if (roll < 45) r.kind = REQ_RESERVE;
    else if (roll < 62) r.kind = allow_search ? REQ_LOW : REQ_TEST;
    else if (roll < 76) r.kind = allow_search ? REQ_HIGH : REQ_FREE;
    else if (roll < 95) r.kind = REQ_TEST;
    else r.kind = 3'($urandom_range(5, 7));
    if ($urandom_range(0, 9) == 0) r.start = 16'($urandom);
    else r.start = 16'($urandom_range(0, lim - 1));
    cnt_top = (lim < 64) ? lim : 64;
    if ($urandom_range(0, 19) == 0) r.count = 17'($urandom_range(0, lim));
    else r.count = 17'($urandom_range(0, cnt_top));
    if ($urandom_range(0, 9) == 0) r.align = 5'($urandom_range(0, 31));
    else r.align = 5'($urandom_range(0, 4));
    return r;
  endfunction

  // Driver: a new word is offered once the previous one has been taken.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready)
        expected_rsps.push_back(serve_page_req(cur_req));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
          cur_req = pending_reqs.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser <= cur_req.kind;
          s_axis_tdata <= {2'd0, cur_req.align, cur_req.count, cur_req.start};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result word and throttles the output side.
  always @(posedge clk) begin
    page_rsp_t want;
    page_rsp_t got;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.ok = m_axis_tdata[0];
        got.found = m_axis_tdata[16:1];
        got.tested = m_axis_tdata[17];
        rsp_seen <= rsp_seen + 1;
        if (expected_rsps.size() == 0) begin
          $display("%0t: unexpected result, actual %h", $time, got);
          errors = errors + 1;
        end else begin
          want = expected_rsps.pop_front();
          if (got.ok !== want.ok) begin
            $display("%0t: ok expected %b actual %b", $time, want.ok, got.ok);
            errors = errors + 1;
          end
          if (got.found !== want.found) begin
            $display("%0t: found_page expected %0d actual %0d", $time, want.found, got.found);
            errors = errors + 1;
          end
          if (got.tested !== want.tested) begin
            $display("%0t: page_allocated expected %b actual %b", $time, want.tested,
                     got.tested);
            errors = errors + 1;
          end
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        m_axis_tready <= 1'b0;
      end else if (m_axis_tvalid && m_axis_tready && rsp_seen == 350) begin
        hold_cycles <= 600;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("page_bitmap_range_allocator test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || s_axis_tvalid || expected_rsps.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_page_limit(int value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data <= value[16:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    page_lim = 64'(value);
  endtask

  initial begin
    int limits[5] = '{64, 1024, 4096, 300, 65536};
    page_busy = '1;
    lowest_freed = NUM_PAGES;
    page_lim = NUM_PAGES;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    pending_reqs.push_back(make_req(REQ_TEST, 0, 0, 0));
    pending_reqs.push_back(make_req(REQ_TEST, 65535, 0, 0));
    pending_reqs.push_back(make_req(REQ_LOW, 0, 65536, 0));
    pending_reqs.push_back(make_req(REQ_FREE, 5, 0, 0));
    pending_reqs.push_back(make_req(REQ_FREE, 65535, 2, 0));
    pending_reqs.push_back(make_req(REQ_FREE, 0, 65536, 0));
    pending_reqs.push_back(make_req(REQ_TEST, 40000, 0, 0));
    pending_reqs.push_back(make_req(REQ_RESERVE, 0, 65536, 0));
    pending_reqs.push_back(make_req(REQ_RESERVE, 10, 0, 0));
    pending_reqs.push_back(make_req(REQ_FREE, 32768, 128, 0));
    pending_reqs.push_back(make_req(REQ_RESERVE, 32800, 8, 0));
    pending_reqs.push_back(make_req(REQ_RESERVE, 32800, 4, 0));
    pending_reqs.push_back(make_req(REQ_LOW, 0, 0, 0));
    pending_reqs.push_back(make_req(REQ_LOW, 0, 16, 4));
    pending_reqs.push_back(make_req(REQ_HIGH, 0, 16, 31));
    pending_reqs.push_back(make_req(REQ_HIGH, 0, 32, 0));
    pending_reqs.push_back(make_req(REQ_HIGH, 0, 0, 0));
    pending_reqs.push_back(make_req(3'd5, 0, 1, 0));
    pending_reqs.push_back(make_req(3'd6, 65535, 65536, 31));
    pending_reqs.push_back(make_req(3'd7, 0, 0, 0));
    pending_reqs.push_back(make_req(REQ_FREE, 0, 64, 0));
    pending_reqs.push_back(make_req(REQ_LOW, 0, 8, 16));
    pending_reqs.push_back(make_req(REQ_TEST, 0, 0, 0));

    write_page_limit(1);
    pending_reqs.push_back(make_req(REQ_TEST, 0, 0, 0));
    pending_reqs.push_back(make_req(REQ_TEST, 1, 0, 0));
    pending_reqs.push_back(make_req(REQ_HIGH, 0, 2, 0));
    pending_reqs.push_back(make_req(REQ_HIGH, 0, 1, 0));

    for (int ph = 0; ph < 5; ph++) begin
      write_page_limit(limits[ph]);
      for (int i = 0; i < 285; i++) begin
        if (ph == 2 && i == 0) begin
          tx_idle_pct = 46;
          rx_idle_pct = 9;
        end else if (ph == 3 && i == 150) begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
        pending_reqs.push_back(random_req(limits[ph], limits[ph] <= 4096));
        if (pending_reqs.size() > 40)
          while (pending_reqs.size() > 10) @(posedge clk);
      end
    end

    wait_drained();
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("page_bitmap_range_allocator test passed");
    end else begin
      $display("page_bitmap_range_allocator test failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
